// File: hdl/sed_pkg.sv
package sed_pkg;

    localparam int STORE_DEPTH_DEF = 131072;

    localparam int SAMPLE_W   = 16;
    localparam int STORE_W    = 32;
    localparam int GAIN_W     = 13;
    localparam int DELAY_W    = 16;
    localparam int MIX_W      = 10;
    localparam int MODE_W     = 2;
    localparam int WEIGHT_W   = 13;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEREO         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIX            = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK_LEFT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FEEDBACK_RIGHT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_CROSS_AMOUNT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_LEFT     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_RIGHT    = 3'd7;

    localparam logic [MODE_W-1:0] MODE_SINGLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEREO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BYPASS   = 2'd3;

    localparam logic [MODE_W-1:0]  RST_MODE           = MODE_SINGLE;
    localparam logic               RST_STEREO         = 1'b1;
    localparam logic [MIX_W-1:0]   RST_MIX            = 10'd500;
    localparam logic [GAIN_W-1:0]  RST_FEEDBACK_LEFT  = 13'd2457;
    localparam logic [GAIN_W-1:0]  RST_FEEDBACK_RIGHT = 13'd2457;
    localparam logic [GAIN_W-1:0]  RST_CROSS_AMOUNT   = 13'd1024;
    localparam logic [DELAY_W-1:0] RST_DELAY_LEFT     = 16'd9600;
    localparam logic [DELAY_W-1:0] RST_DELAY_RIGHT    = 16'd9600;

    localparam int MAC_A_W = 34;
    localparam int MAC_B_W = 14;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = MAC_P_W + 2;

    localparam int Q_SHIFT = 12;
    localparam int UNITY   = 4096;
    localparam int MIX_MAX = 1000;
    localparam int MIX_MID = 500;

    // mix weight = floor(m * 1024 / 125) as a reciprocal multiply
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_K     = ((1 << RECIP_SHIFT) * 1024 + 124) / 125;

    localparam int DIV_W = 30;
    localparam int DEN_W = 14;

    typedef struct packed {
        logic en;
        logic accum;
    } mac_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WGT,
        S_WGT_RES,
        S_RD,
        S_RD_DATA,
        S_ECHO,
        S_ADD,
        S_MIX,
        S_MIX_RES,
        S_CROSS,
        S_DIV_START,
        S_DIV,
        S_SUM,
        S_WR,
        S_DONE
    } state_t;

    function automatic logic signed [STORE_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-STORE_W:0] top_bits;
        top_bits = x[ACC_W-1:STORE_W-1];
        if (top_bits == '0 || top_bits == '1)
            return x[STORE_W-1:0];
        else if (x[ACC_W-1])
            return {1'b1, {(STORE_W-1){1'b0}}};
        else
            return {1'b0, {(STORE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-SAMPLE_W:0] top_bits;
        top_bits = x[ACC_W-1:SAMPLE_W-1];
        if (top_bits == '0 || top_bits == '1)
            return x[SAMPLE_W-1:0];
        else if (x[ACC_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

endpackage

// File: hdl/sed_ram.sv
module sed_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sed_mac.sv
module sed_mac
    import sed_pkg::*;
(
    input  logic                      clk,
    input  mac_op_t                   op,
    input  logic signed [MAC_A_W-1:0] a,
    input  logic signed [MAC_B_W-1:0] b,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [MAC_P_W-1:0] prod;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    always_comb
    begin
        prod     = a * b;
        acc_next = acc_reg;
        if (op.en)
        begin
            acc_next = (op.accum ? acc_reg : '0) + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: hdl/sed_div.sv
module sed_div
    import sed_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [DIV_W-1:0] quo
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] mag_reg, mag_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg, mag_reg[DIV_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            mag_next  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
            rem_next  = '0;
            den_next  = den;
            neg_next  = num[DIV_W-1];
        end
        else if (busy_reg)
        begin
            mag_next = {mag_reg[DIV_W-2:0], fits};
            rem_next = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // truncation toward zero: magnitude quotient, sign restored
    assign quo  = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign done = done_reg;

endmodule

// File: hdl/stereo_echo_delay_top.sv
// channel     | direction | payload (lsb first)
// s_axis      | in        | tdata: left_in[15:0], right_in[31:16]
// m_axis      | out       | tdata: left_out[15:0], right_out[31:16]
// cfg         | in        | cfg_addr selects register, cfg_data holds value
//
// after reset the echo store is zeroed, s_tready low meanwhile
// one frame at a time: s_tready is high only while idle
// plain path: echo plus input, stored and output per channel; bypass: input passed straight out
// mixed path: each channel waits in S_DIV on the 30-step divider
// a finished frame waits in the output register while m_tready is low
module stereo_echo_delay_top
    import sed_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // left_in, right_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // left_out, right_out
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int DIST_W = (ADDR_W > DELAY_W + 1) ? ADDR_W : DELAY_W + 1;
    localparam logic signed [MAC_B_W-1:0] B_ONE = MAC_B_W'(1);

    // configuration registers
    logic [MODE_W-1:0]  mode_reg;
    logic               stereo_reg;
    logic [MIX_W-1:0]   mix_reg;
    logic [GAIN_W-1:0]  feedback_left_reg;
    logic [GAIN_W-1:0]  feedback_right_reg;
    logic [GAIN_W-1:0]  cross_amount_reg;
    logic [DELAY_W-1:0] delay_left_reg;
    logic [DELAY_W-1:0] delay_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= RST_MODE;
            stereo_reg         <= RST_STEREO;
            mix_reg            <= RST_MIX;
            feedback_left_reg  <= RST_FEEDBACK_LEFT;
            feedback_right_reg <= RST_FEEDBACK_RIGHT;
            cross_amount_reg   <= RST_CROSS_AMOUNT;
            delay_left_reg     <= RST_DELAY_LEFT;
            delay_right_reg    <= RST_DELAY_RIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MODE:           mode_reg           <= cfg_data[MODE_W-1:0];
                CFG_STEREO:         stereo_reg         <= cfg_data[0];
                CFG_MIX:            mix_reg            <= cfg_data[MIX_W-1:0];
                CFG_FEEDBACK_LEFT:  feedback_left_reg  <= cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK_RIGHT: feedback_right_reg <= cfg_data[GAIN_W-1:0];
                CFG_CROSS_AMOUNT:   cross_amount_reg   <= cfg_data[GAIN_W-1:0];
                CFG_DELAY_LEFT:     delay_left_reg     <= cfg_data[DELAY_W-1:0];
                CFG_DELAY_RIGHT:    delay_right_reg    <= cfg_data[DELAY_W-1:0];
            endcase
        end
    end

    // sequencer and datapath registers
    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]           pos_reg, pos_next;
    logic                        ch_reg, ch_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic signed [SAMPLE_W-1:0]  l_reg, l_next;
    logic signed [SAMPLE_W-1:0]  r_reg, r_next;
    logic [WEIGHT_W-1:0]         dry_reg, dry_next;
    logic [WEIGHT_W-1:0]         wet_reg, wet_next;
    logic signed [MAC_A_W-1:0]   e_reg, e_next;
    logic signed [SAMPLE_W-1:0]  res_l_reg, res_l_next;
    logic signed [SAMPLE_W-1:0]  res_r_reg, res_r_next;
    logic [31:0]                 m_tdata_reg, m_tdata_next;

    // per-frame decode of the configuration
    logic              plain;
    logic              bypass;
    logic              pingpong;
    logic              sep_right;
    logic [MIX_W-1:0]  mix_clamped;
    logic [MIX_W-1:0]  weight;
    logic [DIST_W-1:0] dist_l;
    logic [DIST_W-1:0] dist_r;
    logic [ADDR_W-1:0] off1;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [GAIN_W-1:0] gain;
    logic signed [SAMPLE_W-1:0] cur_self;
    logic signed [SAMPLE_W-1:0] cur_other;

    always_comb
    begin
        plain       = !stereo_reg || (mode_reg == MODE_SINGLE && cross_amount_reg == '0);
        bypass      = stereo_reg && mode_reg == MODE_BYPASS;
        pingpong    = stereo_reg && mode_reg == MODE_PINGPONG;
        sep_right   = stereo_reg && mode_reg == MODE_STEREO;
        mix_clamped = (mix_reg > MIX_W'(MIX_MAX)) ? MIX_W'(MIX_MAX) : mix_reg;
        weight      = (mix_clamped < MIX_W'(MIX_MID)) ? mix_clamped
                                                       : MIX_W'(MIX_MAX) - mix_clamped;
        dist_l      = stereo_reg ? DIST_W'({delay_left_reg, 1'b0}) : DIST_W'(delay_left_reg);
        dist_r      = sep_right ? DIST_W'({delay_right_reg, 1'b0}) : dist_l;
        off1        = pos_reg + 1'b1;
        rd_addr     = ch_reg ? off1 - dist_r[ADDR_W-1:0] : pos_reg - dist_l[ADDR_W-1:0];
        wr_addr     = (ch_reg ^ pingpong) ? off1 : pos_reg;
        gain        = (ch_reg && sep_right) ? feedback_right_reg : feedback_left_reg;
        cur_self    = ch_reg ? r_reg : l_reg;
        cur_other   = ch_reg ? l_reg : r_reg;
    end

    // shared units
    mac_op_t                     mac_op;
    logic signed [MAC_A_W-1:0]   mac_a;
    logic signed [MAC_B_W-1:0]   mac_b;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     acc_q;
    logic                        div_start;
    logic                        div_done;
    logic signed [DIV_W-1:0]     div_quo;
    logic [DEN_W-1:0]            div_den;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [STORE_W-1:0]          ram_wdata;
    logic                        ram_re;
    logic [STORE_W-1:0]          ram_rdata;
    logic signed [STORE_W-1:0]   store_val;
    logic [WEIGHT_W-1:0]         mix_wgt;

    assign acc_q     = acc >>> Q_SHIFT;
    assign store_val = sat32(acc);
    assign div_den   = DEN_W'(UNITY) + DEN_W'(cross_amount_reg);
    assign mix_wgt   = acc[RECIP_SHIFT +: WEIGHT_W];

    sed_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    sed_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc[DIV_W-1:0]),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    sed_ram #(
        .DATA_W (STORE_W),
        .DEPTH  (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        pos_next      = pos_reg;
        ch_next       = ch_reg;
        m_tvalid_next = m_tvalid_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        dry_next      = dry_reg;
        wet_next      = wet_reg;
        e_next        = e_reg;
        res_l_next    = res_l_reg;
        res_r_next    = res_r_reg;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        mac_op        = '0;
        mac_a         = '0;
        mac_b         = '0;
        div_start     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = wr_addr;
        ram_wdata     = store_val;
        ram_re        = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    l_next     = s_tdata[SAMPLE_W-1:0];
                    r_next     = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    state_next = S_WGT;
                end
            end
            S_WGT:
            begin
                mac_op     = '{en: 1'b1, accum: 1'b0};
                mac_a      = MAC_A_W'(RECIP_K);
                mac_b      = $signed(MAC_B_W'(weight));
                state_next = S_WGT_RES;
            end
            S_WGT_RES:
            begin
                dry_next   = WEIGHT_W'(UNITY);
                wet_next   = WEIGHT_W'(UNITY);
                if (mix_clamped < MIX_W'(MIX_MID))
                begin
                    wet_next = mix_wgt;
                end
                else if (mix_clamped > MIX_W'(MIX_MID))
                begin
                    dry_next = mix_wgt;
                end
                res_r_next = '0;
                ch_next    = 1'b0;
                if (bypass)
                begin
                    res_l_next = l_reg;
                    res_r_next = r_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                mac_op     = '{en: 1'b1, accum: 1'b0};
                mac_a      = MAC_A_W'($signed(ram_rdata));
                mac_b      = $signed({1'b0, gain});
                state_next = S_ECHO;
            end
            S_ECHO:
            begin
                // floor of the Q12 product
                e_next = acc[Q_SHIFT +: MAC_A_W];
                mac_op = '{en: 1'b1, accum: 1'b0};
                mac_a  = MAC_A_W'(cur_self);
                if (plain)
                begin
                    mac_b      = B_ONE;
                    state_next = S_ADD;
                end
                else
                begin
                    mac_b      = $signed({1'b0, dry_reg});
                    state_next = S_MIX;
                end
            end
            S_ADD:
            begin
                mac_op     = '{en: 1'b1, accum: 1'b1};
                mac_a      = e_reg;
                mac_b      = B_ONE;
                state_next = S_WR;
            end
            S_MIX:
            begin
                mac_op     = '{en: 1'b1, accum: 1'b1};
                mac_a      = e_reg;
                mac_b      = $signed({1'b0, wet_reg});
                state_next = S_MIX_RES;
            end
            S_MIX_RES:
            begin
                if (ch_reg)
                begin
                    res_r_next = sat16(acc_q);
                end
                else
                begin
                    res_l_next = sat16(acc_q);
                end
                mac_op     = '{en: 1'b1, accum: 1'b0};
                mac_a      = MAC_A_W'(cur_self);
                mac_b      = MAC_B_W'(UNITY);
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                mac_op     = '{en: 1'b1, accum: 1'b1};
                mac_a      = MAC_A_W'(cur_other);
                mac_b      = $signed({1'b0, cross_amount_reg});
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mac_op     = '{en: 1'b1, accum: 1'b0};
                    mac_a      = MAC_A_W'(div_quo);
                    mac_b      = B_ONE;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                mac_op     = '{en: 1'b1, accum: 1'b1};
                mac_a      = e_reg;
                mac_b      = B_ONE;
                state_next = S_WR;
            end
            S_WR:
            begin
                ram_we = 1'b1;
                if (plain)
                begin
                    if (ch_reg)
                    begin
                        res_r_next = sat16(ACC_W'(store_val));
                    end
                    else
                    begin
                        res_l_next = sat16(ACC_W'(store_val));
                    end
                end
                if (!ch_reg && stereo_reg)
                begin
                    ch_next    = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    pos_next   = pos_reg + (stereo_reg ? ADDR_W'(2) : ADDR_W'(1));
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {res_r_reg, res_l_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            pos_reg      <= '0;
            ch_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            pos_reg      <= pos_next;
            ch_reg       <= ch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg       <= l_next;
        r_reg       <= r_next;
        dry_reg     <= dry_next;
        wet_reg     <= wet_next;
        e_reg       <= e_next;
        res_l_reg   <= res_l_next;
        res_r_reg   <= res_r_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while a frame is in work");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("output raised outside the hand-off state");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished while the sequencer was not waiting");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !m_tvalid && !s_tready)
        else $error("channel active during the store clearing pass");

endmodule
